// ===== rtl/core/ehsk_pkg.sv =====
// ehsk_pkg: shared types and constants of the encoder hold/step keyer
// no dependencies
`timescale 1ns / 1ps
package ehsk_pkg;

  localparam logic [1:0] REQ_DATA    = 2'd0;
  localparam logic [1:0] REQ_PROCESS = 2'd1;
  localparam logic [1:0] REQ_KEY     = 2'd2;
  localparam logic [1:0] REQ_TICK    = 2'd3;

  localparam logic [1:0] ACT_PRESS   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_TAP     = 2'd2;

  localparam logic [2:0] CFG_TIMEOUT  = 3'd0;
  localparam logic [2:0] CFG_GROUP    = 3'd1;
  localparam logic [2:0] CFG_STICKY   = 3'd2;
  localparam logic [2:0] CFG_TOPREQ   = 3'd3;
  localparam logic [2:0] CFG_QREL     = 3'd4;
  localparam logic [2:0] CFG_ACOUNT   = 3'd5;
  localparam logic [2:0] CFG_AKEY0    = 3'd6;
  localparam logic [2:0] CFG_AKEY1    = 3'd7;

  localparam logic [15:0] DEFAULT_TIMEOUT = 16'd180;
  localparam int unsigned CFG_DW = 32;

  typedef struct packed {
    logic [1:0]         req_type;
    logic               sensor_sel;
    logic [2:0]         layer;
    logic [2:0]         top_layer;
    logic signed [15:0] delta_whole;
    logic signed [15:0] delta_fraction;
    logic               trigger_mode;
    logic [15:0]        key_page;
    logic [15:0]        key_id;
    logic               key_pressed;
  } req_t;

  typedef struct packed {
    logic       out_sensor;
    logic [2:0] out_layer;
    logic [1:0] action;
    logic       direction;
    logic       last;
  } res_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture request word
    logic data_wr;   // data item update
    logic proc_rd;   // read addressed entry into work regs
    logic mod_start; // start step counter modulo
    logic mod_step;  // one modulo iteration
    logic proc_wr;   // write back process entry
    logic scan_rd;   // read scan entry
    logic scan_wr;   // write scan entry
    logic scan_inc;  // advance scan index
    logic emit;      // present queued result
  } cmd_t;

  // datapath status to controller
  typedef struct packed {
    logic in_range;
    logic mod_done;
    logic scan_end;
    logic key_hit;
    logic has_result; // queue not empty
  } sts_t;

endpackage

// ===== rtl/core/encoder_hold_step_keyer.sv =====
// encoder_hold_step_keyer: top level, joins controller and datapath
// depends on ehsk_pkg, ehsk_ctrl, ehsk_dpath
`timescale 1ns / 1ps
// usage
//   input: drive req_i and raise start while busy is low; the word is
//   taken at that edge and busy stays high until every result is out
//   results: res_valid_o marks res_o for exactly one cycle; res_o.last flags
//   the final action of the word. The receiver cannot stall the block.
//   config: cfg_we_i writes register cfg_idx_i with cfg_data_i; write only
//   while idle, the block does not enforce it. sequence: a data word is done
//   after dispatch; a gated-in trigger with a pending direction and taps enabled
//   also runs the 16-step bit-serial remainder unit, other process words skip
//   it, each then emits one result per action; ticks and releasing key words
//   scan every entry by read, write and emit, one result per released hold; a
//   key word that releases nothing ends at dispatch; no new word while busy
//   reset: all entries clear at once, config returns to defaults, no result
module encoder_hold_step_keyer #(
  parameter int unsigned SENSORS       = 2,
  parameter int unsigned LAYERS        = 8,
  parameter int unsigned ALLOW_ENTRIES = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  ehsk_pkg::req_t              req_i,
  output logic                        res_valid_o,
  output ehsk_pkg::res_t              res_o,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [ehsk_pkg::CFG_DW-1:0] cfg_data_i
);
  import ehsk_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  ehsk_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start),
    .req_type_i(req_i.req_type), .sts_i(sts), .cmd_o(cmd), .busy_o(busy)
  );

  // datapath
  ehsk_dpath #(.SENSORS(SENSORS), .LAYERS(LAYERS), .ALLOW_ENTRIES(ALLOW_ENTRIES)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_i),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .cmd_i(cmd), .sts_o(sts), .res_valid_o(res_valid_o), .res_o(res_o)
  );
endmodule

// ===== rtl/core/ehsk_ctrl.sv =====
// ehsk_ctrl: sequencer of the keyer, drives datapath commands
// depends on ehsk_pkg
`timescale 1ns / 1ps
module ehsk_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [1:0]      req_type_i,
  input  ehsk_pkg::sts_t  sts_i,
  output ehsk_pkg::cmd_t  cmd_o,
  output logic            busy_o
);
  import ehsk_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_PRD  = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_PWR  = 3'd4;
  localparam logic [2:0] S_SRD  = 3'd5;
  localparam logic [2:0] S_SWR  = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0] state_q, state_d;
  logic [1:0] req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q   <= REQ_DATA;
    end else begin
      state_q <= state_d;
      if (start_i && state_q == S_IDLE) req_q <= req_type_i;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (req_q)
          REQ_DATA: begin
            cmd_o.data_wr = 1'b1;
            state_d = S_IDLE;
          end
          REQ_PROCESS: begin
            if (sts_i.in_range) begin
              cmd_o.proc_rd = 1'b1;
              state_d = S_PRD;
            end else begin
              state_d = S_IDLE;
            end
          end
          REQ_KEY: state_d = sts_i.key_hit ? S_SRD : S_IDLE;
          default: state_d = S_SRD;
        endcase
      end
      S_PRD: begin
        cmd_o.mod_start = 1'b1;
        state_d = S_MOD;
      end
      S_MOD: begin
        if (sts_i.mod_done) begin
          state_d = S_PWR;
        end else begin
          cmd_o.mod_step = 1'b1;
        end
      end
      S_PWR: begin
        cmd_o.proc_wr = 1'b1;
        state_d = S_EMIT;
      end
      S_SRD: begin
        cmd_o.scan_rd = 1'b1;
        state_d = S_SWR;
      end
      S_SWR: begin
        cmd_o.scan_wr = 1'b1;
        cmd_o.scan_inc = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.has_result) begin
          cmd_o.emit = 1'b1;
        end else if (req_q == REQ_PROCESS || sts_i.scan_end) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_SRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
endmodule

// ===== rtl/core/ehsk_dpath.sv =====
// ehsk_dpath: entry store, config registers, modulo unit, result queue
// depends on ehsk_pkg
`timescale 1ns / 1ps
module ehsk_dpath #(
  parameter int unsigned SENSORS       = 2,
  parameter int unsigned LAYERS        = 8,
  parameter int unsigned ALLOW_ENTRIES = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ehsk_pkg::req_t                req_i,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [ehsk_pkg::CFG_DW-1:0]   cfg_data_i,
  input  ehsk_pkg::cmd_t                cmd_i,
  output ehsk_pkg::sts_t                sts_o,
  output logic                          res_valid_o,
  output ehsk_pkg::res_t                res_o
);
  import ehsk_pkg::*;

  localparam int unsigned ENTRIES = SENSORS * LAYERS;
  localparam int unsigned EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // config registers
  logic [15:0] timeout_q, group_q;
  logic        sticky_q, topreq_q, qrel_q;
  logic [1:0]  acount_q;
  logic [31:0] akey0_q, akey1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= DEFAULT_TIMEOUT;
      group_q   <= 16'd5;
      sticky_q  <= 1'b0;
      topreq_q  <= 1'b1;
      qrel_q    <= 1'b0;
      acount_q  <= 2'd0;
      akey0_q   <= '0;
      akey1_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TIMEOUT: timeout_q <= cfg_data_i[15:0];
        CFG_GROUP:   group_q   <= cfg_data_i[15:0];
        CFG_STICKY:  sticky_q  <= cfg_data_i[0];
        CFG_TOPREQ:  topreq_q  <= cfg_data_i[0];
        CFG_QREL:    qrel_q    <= cfg_data_i[0];
        CFG_ACOUNT:  acount_q  <= cfg_data_i[1:0];
        CFG_AKEY0:   akey0_q   <= cfg_data_i;
        CFG_AKEY1:   akey1_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured request word
  req_t r_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) r_q <= req_i;
  end

  // entry state, reset-cleared flops
  logic [1:0]  pend_q  [ENTRIES];
  logic        hact_q  [ENTRIES];
  logic        hdir_q  [ENTRIES];
  logic [15:0] step_q  [ENTRIES];
  logic [15:0] timer_q [ENTRIES];

  logic in_range, gate_ok;
  logic [EW-1:0] addr;
  assign in_range = ({31'd0, r_q.sensor_sel} < SENSORS) && ({29'd0, r_q.layer} < LAYERS);
  assign addr = EW'(32'(r_q.sensor_sel) * LAYERS + 32'(r_q.layer));
  assign gate_ok = !topreq_q || (r_q.layer == r_q.top_layer);

  // key check
  logic is_mod, allowed, key_hit;
  logic [31:0] keyv;
  assign keyv = {r_q.key_page, r_q.key_id};
  assign is_mod = (r_q.key_page == 16'd7) && (r_q.key_id >= 16'hE0) && (r_q.key_id <= 16'hE7);
  assign allowed = (ALLOW_ENTRIES >= 1 && acount_q >= 2'd1 && akey0_q == keyv) ||
                   (ALLOW_ENTRIES >= 2 && acount_q >= 2'd2 && akey1_q == keyv);
  assign key_hit = r_q.key_pressed && !is_mod && qrel_q && !allowed;

  // working registers for process item
  logic [1:0]  w_pend_q;
  logic        w_hact_q, w_hdir_q;
  logic [15:0] w_step_q, w_rem_q;
  logic [4:0]  m_cnt_q;
  logic        m_busy_q;

  // scan index
  logic [EW:0] sidx_q;
  logic [EW-1:0] sidx;
  assign sidx = sidx_q[EW-1:0];
  logic        s_hact_q, s_hdir_q;
  logic [15:0] s_timer_q;

  // result queue of four slots, at most three per process item, one per scan entry
  res_t        rq_q [4];
  logic [2:0]  rcnt_q;
  logic [1:0]  rhead_q;

  logic [15:0] stepn;
  assign stepn = w_step_q + 16'd1;

  // restoring remainder of stepn by group, one bit per cycle
  logic [15:0] quo_q;   // dividend bits left
  logic [16:0] rem_sh;
  assign rem_sh = {w_rem_q, quo_q[15]};

  logic proc_dir;
  assign proc_dir = (w_pend_q != 2'd1);

  // split entry index into sensor and layer; the sensor field is one bit wide
  function automatic res_t mk(input logic [EW-1:0] e, input logic [1:0] a, input logic d);
    res_t r;
    logic hi;
    hi = (32'(e) >= LAYERS);
    r.out_sensor = hi;
    r.out_layer  = 3'(32'(e) - (hi ? LAYERS : 32'd0));
    r.action     = a;
    r.direction  = d;
    r.last       = 1'b0;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        pend_q[i] <= '0; hact_q[i] <= 1'b0; hdir_q[i] <= 1'b0;
        step_q[i] <= '0; timer_q[i] <= '0;
      end
      rcnt_q  <= '0;
      rhead_q <= '0;
      sidx_q  <= '0;
      m_cnt_q <= '0;
      m_busy_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        sidx_q <= '0;
        rcnt_q <= '0;
        rhead_q <= '0;
      end
      // data item
      if (cmd_i.data_wr && in_range) begin
        if (!gate_ok) begin
          pend_q[addr] <= 2'd0;
          step_q[addr] <= '0;
        end else begin
          logic [15:0] d;
          d = (r_q.delta_whole != 0) ? r_q.delta_whole : r_q.delta_fraction;
          pend_q[addr] <= (d == 0) ? 2'd0 : (d[15] ? 2'd2 : 2'd1);
        end
      end
      if (cmd_i.proc_rd) begin
        w_pend_q <= pend_q[addr];
        w_hact_q <= hact_q[addr];
        w_hdir_q <= hdir_q[addr];
        w_step_q <= step_q[addr];
      end
      // modulo: 16 iterations when a tap check is needed
      if (cmd_i.mod_start) begin
        w_rem_q  <= '0;
        quo_q    <= stepn;
        m_cnt_q  <= 5'd0;
        m_busy_q <= gate_ok && r_q.trigger_mode && (w_pend_q != 2'd0) && (group_q != 0);
      end
      if (cmd_i.mod_step) begin
        if (rem_sh >= {1'b0, group_q}) w_rem_q <= 16'(rem_sh - {1'b0, group_q});
        else                           w_rem_q <= rem_sh[15:0];
        quo_q   <= {quo_q[14:0], 1'b0};
        m_cnt_q <= m_cnt_q + 5'd1;
        if (m_cnt_q == 5'd15) m_busy_q <= 1'b0;
      end
      // process write back and result build
      if (cmd_i.proc_wr) begin
        logic [2:0] n;
        n = '0;
        pend_q[addr] <= 2'd0;
        if (!gate_ok) begin
          if (w_hact_q) begin
            rq_q[n[1:0]] <= mk(addr, ACT_RELEASE, w_hdir_q); n = n + 3'd1;
          end
          hact_q[addr] <= 1'b0;
          step_q[addr] <= '0;
          timer_q[addr] <= '0;
        end else if (r_q.trigger_mode && w_pend_q != 2'd0) begin
          if (group_q == 0) step_q[addr] <= '0;
          else begin
            step_q[addr] <= stepn;
            if (w_rem_q == 0) begin
              rq_q[n[1:0]] <= mk(addr, ACT_TAP, proc_dir); n = n + 3'd1;
            end
          end
          if (!w_hact_q) begin
            hact_q[addr] <= 1'b1;
            hdir_q[addr] <= proc_dir;
            rq_q[n[1:0]] <= mk(addr, ACT_PRESS, proc_dir); n = n + 3'd1;
          end else if (!sticky_q && w_hdir_q != proc_dir) begin
            rq_q[n[1:0]] <= mk(addr, ACT_RELEASE, w_hdir_q); n = n + 3'd1;
            hdir_q[addr] <= proc_dir;
            rq_q[n[1:0]] <= mk(addr, ACT_PRESS, proc_dir); n = n + 3'd1;
          end
          timer_q[addr] <= (timeout_q != 0) ? timeout_q : DEFAULT_TIMEOUT;
        end
        rcnt_q <= n;
        rhead_q <= '0;
      end
      if (cmd_i.scan_rd) begin
        s_hact_q  <= hact_q[sidx];
        s_hdir_q  <= hdir_q[sidx];
        s_timer_q <= timer_q[sidx];
      end
      if (cmd_i.scan_wr) begin
        rhead_q <= '0;
        if (r_q.req_type == REQ_KEY) begin
          pend_q[sidx] <= 2'd0;
          hact_q[sidx] <= 1'b0;
          step_q[sidx] <= '0;
          timer_q[sidx] <= '0;
          if (s_hact_q) begin
            rq_q[0] <= mk(sidx, ACT_RELEASE, s_hdir_q);
            rcnt_q <= 3'd1;
          end
        end else if (s_hact_q && s_timer_q != 0) begin
          timer_q[sidx] <= s_timer_q - 16'd1;
          if (s_timer_q == 16'd1) begin
            hact_q[sidx] <= 1'b0;
            step_q[sidx] <= '0;
            rq_q[0] <= mk(sidx, ACT_RELEASE, s_hdir_q);
            rcnt_q <= 3'd1;
          end
        end
      end
      if (cmd_i.scan_inc) sidx_q <= sidx_q + 1'b1;
      if (cmd_i.emit) begin
        rcnt_q  <= rcnt_q - 3'd1;
        rhead_q <= rhead_q + 2'd1;
      end
    end
  end

  // is any release still ahead in the scan
  logic later;
  always_comb begin
    later = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (i >= 32'(sidx_q)) begin
        if (r_q.req_type == REQ_KEY) later = later | hact_q[i];
        else later = later | (hact_q[i] && timer_q[i] == 16'd1);
      end
    end
  end

  logic is_last;
  assign is_last = (rcnt_q == 3'd1) &&
                   (r_q.req_type == REQ_PROCESS || !later);

  always_comb begin
    res_o = rq_q[rhead_q];
    res_o.last = is_last;
  end
  assign res_valid_o = cmd_i.emit;

  assign sts_o.in_range   = in_range;
  assign sts_o.mod_done   = !m_busy_q;
  assign sts_o.scan_end   = (sidx_q == (EW+1)'(ENTRIES));
  assign sts_o.key_hit    = key_hit;
  assign sts_o.has_result = (rcnt_q != 0);
endmodule

// ===== rtl/core/ehsk_checker.sv =====
// ehsk_checker: port-level checks of the keyer, bound to the top level
// depends on ehsk_pkg
`timescale 1ns / 1ps
module ehsk_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           res_valid_o,
  input ehsk_pkg::res_t res_o
);
  import ehsk_pkg::*;

  // results only while a word is in work
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy) else $error("result while idle");

  // accepted word makes block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start not taken");

  // no action code beyond tap
  a_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.action != 2'd3)) else $error("bad action");

  // last word ends the burst
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |=> !res_valid_o) else $error("word after last");
endmodule

bind encoder_hold_step_keyer ehsk_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .res_valid_o(res_valid_o), .res_o(res_o)
);

// ===== tb/encoder_hold_step_keyer_test.sv =====
// encoder_hold_step_keyer_test: self-checking bench for the encoder hold/step keyer
// depends on ehsk_pkg and encoder_hold_step_keyer
`timescale 1ns / 1ps

// scoreboard: own model of the keyer plus the queue of actions it predicts
class keyer_scoreboard;
  localparam int NENT = 16;
  logic [15:0] hold_timeout, group_size;
  logic        sticky, top_req, qrel;
  logic [1:0]  acount;
  logic [31:0] akey [2];
  logic [1:0]  pend [NENT];
  logic        hold [NENT];
  logic        hdir [NENT];
  logic [15:0] steps [NENT];
  logic [15:0] timer [NENT];
  ehsk_pkg::res_t pending_actions [$];
  int errors;

  function new();
    hold_timeout = 16'd180; group_size = 16'd5; sticky = 0; top_req = 1; qrel = 0;
    acount = 0; akey[0] = 0; akey[1] = 0; errors = 0;
    for (int e = 0; e < NENT; e++) begin
      pend[e] = 0; hold[e] = 0; hdir[e] = 0; steps[e] = 0; timer[e] = 0;
    end
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      ehsk_pkg::CFG_TIMEOUT: hold_timeout = v[15:0];
      ehsk_pkg::CFG_GROUP:   group_size = v[15:0];
      ehsk_pkg::CFG_STICKY:  sticky = v[0];
      ehsk_pkg::CFG_TOPREQ:  top_req = v[0];
      ehsk_pkg::CFG_QREL:    qrel = v[0];
      ehsk_pkg::CFG_ACOUNT:  acount = v[1:0];
      ehsk_pkg::CFG_AKEY0:   akey[0] = v;
      default:               akey[1] = v;
    endcase
  endfunction

  function void push_action(int e, logic [1:0] act, logic d);
    ehsk_pkg::res_t r;
    r.out_sensor = 1'(e / 8); r.out_layer = 3'(e % 8);
    r.action = act; r.direction = d; r.last = 0;
    pending_actions.push_back(r);
  endfunction

  function void drop_hold(int e);
    if (hold[e]) begin
      push_action(e, ehsk_pkg::ACT_RELEASE, hdir[e]);
      hold[e] = 0;
    end
    steps[e] = 0; timer[e] = 0;
  endfunction

  // note an accepted input word and predict its actions
  function void note_word(ehsk_pkg::req_t q);
    int base, e;
    logic gate, d, allowed, ismod;
    logic [15:0] delta;
    logic [1:0] pd;
    logic [31:0] key;
    base = pending_actions.size();
    e = q.sensor_sel * 8 + q.layer;
    gate = !top_req || (q.layer == q.top_layer);
    case (q.req_type)
      ehsk_pkg::REQ_DATA: begin
        delta = (q.delta_whole != 0) ? q.delta_whole : q.delta_fraction;
        if (!gate) begin
          pend[e] = 0; steps[e] = 0;
        end else if (delta == 0) pend[e] = 0;
        else pend[e] = delta[15] ? 2'd2 : 2'd1;
      end
      ehsk_pkg::REQ_PROCESS: begin
        if (!gate) begin
          pend[e] = 0; drop_hold(e);
        end else if (!q.trigger_mode) pend[e] = 0;
        else begin
          pd = pend[e]; pend[e] = 0;
          if (pd != 0) begin
            d = (pd != 2'd1);
            if (group_size == 0) steps[e] = 0;
            else begin
              steps[e] = steps[e] + 16'd1;
              if (steps[e] % group_size == 0) push_action(e, ehsk_pkg::ACT_TAP, d);
            end
            if (!hold[e]) begin
              hold[e] = 1; hdir[e] = d; push_action(e, ehsk_pkg::ACT_PRESS, d);
            end else if (!sticky && hdir[e] != d) begin
              push_action(e, ehsk_pkg::ACT_RELEASE, hdir[e]);
              hdir[e] = d; push_action(e, ehsk_pkg::ACT_PRESS, d);
            end
            timer[e] = (hold_timeout != 0) ? hold_timeout : ehsk_pkg::DEFAULT_TIMEOUT;
          end
        end
      end
      ehsk_pkg::REQ_KEY: begin
        ismod = (q.key_page == 16'd7) && (q.key_id >= 16'hE0) && (q.key_id <= 16'hE7);
        key = {q.key_page, q.key_id};
        allowed = 0;
        for (int i = 0; i < 2; i++)
          if (i < acount && akey[i] == key) allowed = 1;
        if (q.key_pressed && !ismod && qrel && !allowed)
          for (int k = 0; k < NENT; k++) begin
            pend[k] = 0; drop_hold(k);
          end
      end
      default: begin
        for (int k = 0; k < NENT; k++)
          if (hold[k] && timer[k] != 0) begin
            timer[k] = timer[k] - 16'd1;
            if (timer[k] == 0) drop_hold(k);
          end
      end
    endcase
    if (pending_actions.size() > base) pending_actions[pending_actions.size() - 1].last = 1;
  endfunction

  // compare one result with the oldest predicted action
  function void check_action(ehsk_pkg::res_t got);
    ehsk_pkg::res_t exp_r;
    if (pending_actions.size() == 0) begin
      $display("%0t: unexpected result %h", $realtime, got);
      errors++;
      return;
    end
    exp_r = pending_actions.pop_front();
    if (exp_r != got) begin
      $display("%0t: mismatch expected %h actual %h", $realtime, exp_r, got);
      errors++;
    end
  endfunction
endclass

module encoder_hold_step_keyer_test;
  import ehsk_pkg::*;

  logic clk_i = 0, rst_ni = 0, start = 0, cfg_we_i = 0;
  logic busy, res_valid_o;
  req_t req_i = '0;
  res_t res_o;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  keyer_scoreboard board;
  int cycles = 0;
  localparam int CYCLE_LIMIT = 400000;

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  encoder_hold_step_keyer dut (.*);

  // result sampling and timeout watch
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && res_valid_o) board.check_action(res_o);
    if (cycles > CYCLE_LIMIT) begin
      $display("[encoder_hold_step_keyer] ERROR");
      $finish;
    end
  end

  // hold start until an edge with busy low takes the word
  task automatic send_word(req_t q);
    start <= 1; req_i <= q;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_word(q);
    start <= 0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    board.write_reg(idx, v);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  // let the block drain before reconfiguring
  task automatic drain();
    while (board.pending_actions.size() != 0 || busy) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic req_t mk(logic [1:0] t, logic s, logic [2:0] l, logic [2:0] tl,
                              logic [15:0] w, logic [15:0] f, logic tr);
    req_t q;
    q = '0;
    q.req_type = t; q.sensor_sel = s; q.layer = l; q.top_layer = tl;
    q.delta_whole = w; q.delta_fraction = f; q.trigger_mode = tr;
    return q;
  endfunction

  function automatic req_t mk_key(logic [15:0] p, logic [15:0] i, logic pr);
    req_t q;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    q = raw[$bits(req_t)-1:0];
    q.req_type = REQ_KEY; q.key_page = p; q.key_id = i; q.key_pressed = pr;
    return q;
  endfunction

  function automatic req_t rand_word(logic [2:0] tl);
    req_t q;
    int r;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    q = raw[$bits(req_t)-1:0];
    r = $urandom_range(0, 99);
    q.top_layer = tl;
    if ($urandom_range(0, 9) != 0) q.layer = tl;
    if (r < 40) q.req_type = REQ_DATA;
    else if (r < 75) begin
      q.req_type = REQ_PROCESS;
      if ($urandom_range(0, 5) != 0) q.trigger_mode = 1'b1;
    end else if (r < 85) begin
      q.req_type = REQ_KEY;
      case ($urandom_range(0, 3))
        0: begin q.key_page = 16'd7; q.key_id = 16'(16'hE0 + $urandom_range(0, 8)); end
        1: begin q.key_page = board.akey[0][31:16]; q.key_id = board.akey[0][15:0]; end
        default: ;
      endcase
    end else q.req_type = REQ_TICK;
    if (q.req_type == REQ_DATA && $urandom_range(0, 7) == 0) q.delta_whole = '0;
    return q;
  endfunction

  task automatic random_phase(int n);
    logic [2:0] tl;
    tl = 3'($urandom);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) tl = 3'($urandom);
      send_word(rand_word(tl));
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  endtask

  initial begin
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: press, step taps, reversal, gate, modifier, release, ticks
    send_word(mk(REQ_DATA, 0, 3, 3, 16'h0001, 0, 0));
    send_word(mk(REQ_PROCESS, 0, 3, 3, 0, 0, 1));
    send_word(mk(REQ_DATA, 0, 3, 3, 16'h0000, 16'h8000, 0));
    send_word(mk(REQ_PROCESS, 0, 3, 3, 0, 0, 1));
    send_word(mk(REQ_DATA, 0, 3, 3, 16'h7FFF, 0, 0));
    send_word(mk(REQ_PROCESS, 0, 3, 3, 0, 0, 0));
    for (int i = 0; i < 5; i++) begin
      send_word(mk(REQ_DATA, 1, 7, 7, 16'hFFFF, 16'h7FFF, 0));
      send_word(mk(REQ_PROCESS, 1, 7, 7, 0, 0, 1));
    end
    send_word(mk(REQ_DATA, 1, 0, 7, 16'h0000, 16'h0000, 0));
    send_word(mk(REQ_PROCESS, 1, 7, 0, 0, 0, 1));
    send_word(mk_key(16'h0007, 16'h00E7, 1));
    send_word(mk_key(16'hFFFF, 16'hFFFF, 0));
    for (int i = 0; i < 4; i++) send_word(mk(REQ_TICK, 0, 0, 0, 0, 0, 0));
    drain();

    // short timeout, sticky, quick release with allow list, no gate, no taps
    write_reg(CFG_TIMEOUT, 32'd2);
    write_reg(CFG_GROUP, 32'd0);
    write_reg(CFG_STICKY, 32'd1);
    write_reg(CFG_TOPREQ, 32'd0);
    write_reg(CFG_QREL, 32'd1);
    write_reg(CFG_ACOUNT, 32'd3);
    write_reg(CFG_AKEY0, 32'h0004_0005);
    write_reg(CFG_AKEY1, 32'hFFFF_FFFF);
    send_word(mk(REQ_DATA, 0, 1, 5, 16'h8000, 0, 0));
    send_word(mk(REQ_PROCESS, 0, 1, 5, 0, 0, 1));
    send_word(mk_key(16'h0004, 16'h0005, 1));
    send_word(mk_key(16'hFFFF, 16'hFFFF, 1));
    send_word(mk_key(16'h0007, 16'h00E8, 1));
    random_phase(110);
    drain();

    // wide timeout extreme, group of one, switch mode, gate on
    write_reg(CFG_TIMEOUT, 32'hFFFF);
    write_reg(CFG_GROUP, 32'd1);
    write_reg(CFG_STICKY, 32'd0);
    write_reg(CFG_TOPREQ, 32'd1);
    write_reg(CFG_ACOUNT, 32'd1);
    random_phase(100);
    drain();

    // timeout zero means default, huge group, quick release off
    write_reg(CFG_TIMEOUT, 32'd0);
    write_reg(CFG_GROUP, 32'hFFFF);
    write_reg(CFG_QREL, 32'd0);
    random_phase(50);
    drain();
    write_reg(CFG_TIMEOUT, 32'd3);
    write_reg(CFG_GROUP, 32'd3);
    write_reg(CFG_QREL, 32'd1);
    write_reg(CFG_ACOUNT, 32'd2);
    write_reg(CFG_AKEY1, 32'h0000_0000);
    random_phase(150);

    drain();
    if (board.errors == 0 && board.pending_actions.size() == 0)
      $display("[encoder_hold_step_keyer] OK");
    else
      $display("[encoder_hold_step_keyer] ERROR");
    $finish;
  end
endmodule
